// File: sv/fbsda_pkg.sv
package fbsda_pkg;

  localparam int unsigned SW = 50;  // working significand width of the rounding path

  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [15:0] BF16_QNAN   = 16'h7FC0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SMUL,
    ST_PMUL,
    ST_TADD,
    ST_FIN
  } st_e;

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // leading zero count, 50 when the word is zero
  function automatic logic [5:0] lzc(logic [SW-1:0] v);
    logic [5:0] n;
    n = 6'(SW);
    for (int i = 0; i < SW; i++) begin
      if (v[i]) n = 6'(SW - 1 - i);
    end
    return n;
  endfunction

  // sig has its msb at the top bit (or is zero); value is 1.f * 2^e
  function automatic logic [31:0] round_pack(logic s, logic signed [11:0] e,
                                             logic [SW-1:0] sig);
    logic signed [11:0] bexp;
    logic [11:0] sh;
    logic [5:0] sh6;
    logic [7:0] base;
    logic ovf;
    logic [SW-1:0] shd;
    logic [SW-1:0] mask;
    logic lost;
    logic [23:0] m;
    logic g;
    logic st;
    logic up;
    logic [24:0] mr;
    logic [30:0] sum;
    logic [31:0] r;
    bexp = e + 12'sd127;
    ovf  = 1'b0;
    if (bexp >= 12'sd1) begin
      sh   = 12'd0;
      ovf  = bexp > 12'sd254;
      base = ovf ? 8'd0 : 8'(bexp - 12'sd1);
    end else begin
      sh   = 12'(12'sd1 - bexp);
      base = 8'd0;
    end
    sh6  = (sh > 12'(SW)) ? 6'(SW) : sh[5:0];
    mask = ~({SW{1'b1}} << sh6);
    shd  = sig >> sh6;
    lost = |(sig & mask);
    m    = shd[SW-1 -: 24];
    g    = shd[SW-25];
    st   = (|shd[SW-26:0]) | lost;
    up   = g & (st | m[0]);
    mr   = {1'b0, m} + 25'(up);
    sum  = {base, 23'd0} + {6'd0, mr};
    if (sig == '0) begin
      r = {s, 31'd0};
    end else if (ovf || (sum >= 31'h7F80_0000)) begin
      r = {s, 8'hFF, 23'd0};
    end else begin
      r = {s, sum};
    end
    return r;
  endfunction

  function automatic logic [15:0] to_bf16(logic [31:0] b);
    logic [31:0] t;
    t = b + 32'h0000_7FFF + {31'd0, b[16]};
    if (is_nan(b)) return {b[31], 15'd0} | BF16_QNAN;
    return t[31:16];
  endfunction

endpackage

// File: sv/fbsda_lane.sv
module fbsda_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [7:0]  a_i,
  input  logic [7:0]  b_i,
  output logic [31:0] prod_o
);

  logic [31:0] prod_q, prod_d;

  logic [3:0] sig_a, sig_b;
  logic signed [4:0] ex_a, ex_b;
  logic [7:0] p;
  logic signed [11:0] ex;
  logic [5:0] lz;
  logic nan_a, nan_b;

  always_comb begin
    nan_a = (a_i[6:0] == 7'h7F);
    nan_b = (b_i[6:0] == 7'h7F);
    sig_a = {a_i[6:3] != 4'd0, a_i[2:0]};
    sig_b = {b_i[6:3] != 4'd0, b_i[2:0]};
    ex_a  = (a_i[6:3] == 4'd0) ? -5'sd6 : $signed({1'b0, a_i[6:3]}) - 5'sd7;
    ex_b  = (b_i[6:3] == 4'd0) ? -5'sd6 : $signed({1'b0, b_i[6:3]}) - 5'sd7;
    p     = 8'(sig_a * sig_b);
    ex    = 12'(ex_a) + 12'(ex_b) + 12'sd1;
    lz    = fbsda_pkg::lzc({p, 42'd0});
    if (nan_a) begin
      prod_d = {a_i[7], 31'd0} | 32'h7FC0_0000;
    end else if (nan_b) begin
      prod_d = {b_i[7], 31'd0} | 32'h7FC0_0000;
    end else begin
      prod_d = fbsda_pkg::round_pack(a_i[7] ^ b_i[7], ex - 12'(lz),
                                     {p, 42'd0} << lz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: sv/fbsda_fadd.sv
module fbsda_fadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic [31:0] res_o
);

  localparam int unsigned W = fbsda_pkg::SW;

  logic v1_q, v2_q;
  logic [W-1:0] sum_q, sum_d;
  logic signed [11:0] ex_q, ex_d;
  logic sgn_q, sgn_d;
  logic spc_q, spc_d;
  logic [31:0] spv_q, spv_d;
  logic [31:0] res_q, res_d;

  logic [31:0] big, sml;
  logic [23:0] sig_b, sig_s;
  logic signed [9:0] e_b, e_s;
  logic [9:0] d;
  logic [5:0] d6;
  logic [W-1:0] opa, opb, shb, mask;
  logic lz_st;
  logic [5:0] lz;

  always_comb begin
    if (a_i[30:0] >= b_i[30:0]) begin
      big = a_i;
      sml = b_i;
    end else begin
      big = b_i;
      sml = a_i;
    end
    sig_b = {big[30:23] != 8'd0, big[22:0]};
    sig_s = {sml[30:23] != 8'd0, sml[22:0]};
    e_b   = (big[30:23] == 8'd0) ? -10'sd126 : $signed({2'b0, big[30:23]}) - 10'sd127;
    e_s   = (sml[30:23] == 8'd0) ? -10'sd126 : $signed({2'b0, sml[30:23]}) - 10'sd127;
    d     = 10'(e_b - e_s);
    d6    = (d > 10'(W)) ? 6'(W) : d[5:0];
    opa   = {1'b0, sig_b, 25'd0};
    opb   = {1'b0, sig_s, 25'd0};
    mask  = ~({W{1'b1}} << d6);
    lz_st = |(opb & mask);
    shb   = (opb >> d6) | {{(W-1){1'b0}}, lz_st};
    sum_d = (a_i[31] ^ b_i[31]) ? (opa - shb) : (opa + shb);
    ex_d  = 12'(e_b) + 12'sd1;
    sgn_d = (sum_d == '0) ? (a_i[31] & b_i[31]) : big[31];
    spc_d = 1'b1;
    if (fbsda_pkg::is_nan(a_i)) begin
      spv_d = a_i | fbsda_pkg::QNAN_BIT;
    end else if (fbsda_pkg::is_nan(b_i)) begin
      spv_d = b_i | fbsda_pkg::QNAN_BIT;
    end else if (fbsda_pkg::is_inf(a_i) && fbsda_pkg::is_inf(b_i) && (a_i[31] != b_i[31])) begin
      spv_d = fbsda_pkg::DEFAULT_NAN;
    end else if (fbsda_pkg::is_inf(a_i)) begin
      spv_d = a_i;
    end else if (fbsda_pkg::is_inf(b_i)) begin
      spv_d = b_i;
    end else begin
      spv_d = a_i;
      spc_d = 1'b0;
    end
  end

  always_comb begin
    lz    = fbsda_pkg::lzc(sum_q);
    res_d = spc_q ? spv_q
                  : fbsda_pkg::round_pack(sgn_q, ex_q - 12'(lz), sum_q << lz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    ex_q  <= ex_d;
    sgn_q <= sgn_d;
    spc_q <= spc_d;
    spv_q <= spv_d;
    res_q <= res_d;
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;

endmodule

// File: sv/fbsda_fmul.sv
module fbsda_fmul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic [31:0] res_o
);

  logic v1_q, v2_q;
  logic [47:0] p_q, p_d;
  logic signed [11:0] ex_q, ex_d;
  logic sgn_q, sgn_d;
  logic spc_q, spc_d;
  logic [31:0] spv_q, spv_d;
  logic [31:0] res_q, res_d;

  logic [23:0] sig_a, sig_b;
  logic signed [9:0] e_a, e_b;
  logic [5:0] lz;

  always_comb begin
    sig_a = {a_i[30:23] != 8'd0, a_i[22:0]};
    sig_b = {b_i[30:23] != 8'd0, b_i[22:0]};
    e_a   = (a_i[30:23] == 8'd0) ? -10'sd126 : $signed({2'b0, a_i[30:23]}) - 10'sd127;
    e_b   = (b_i[30:23] == 8'd0) ? -10'sd126 : $signed({2'b0, b_i[30:23]}) - 10'sd127;
    p_d   = sig_a * sig_b;
    ex_d  = 12'(e_a) + 12'(e_b) + 12'sd1;
    sgn_d = a_i[31] ^ b_i[31];
    spc_d = 1'b1;
    if (fbsda_pkg::is_nan(a_i)) begin
      spv_d = a_i | fbsda_pkg::QNAN_BIT;
    end else if (fbsda_pkg::is_nan(b_i)) begin
      spv_d = b_i | fbsda_pkg::QNAN_BIT;
    end else if ((fbsda_pkg::is_inf(a_i) && fbsda_pkg::is_zero(b_i)) ||
                 (fbsda_pkg::is_zero(a_i) && fbsda_pkg::is_inf(b_i))) begin
      spv_d = fbsda_pkg::DEFAULT_NAN;
    end else if (fbsda_pkg::is_inf(a_i) || fbsda_pkg::is_inf(b_i)) begin
      spv_d = {sgn_d, 8'hFF, 23'd0};
    end else begin
      spv_d = a_i;
      spc_d = 1'b0;
    end
  end

  always_comb begin
    lz    = fbsda_pkg::lzc({p_q, 2'b00});
    res_d = spc_q ? spv_q
                  : fbsda_pkg::round_pack(sgn_q, ex_q - 12'(lz), {p_q, 2'b00} << lz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    ex_q  <= ex_d;
    sgn_q <= sgn_d;
    spc_q <= spc_d;
    spv_q <= spv_d;
    res_q <= res_d;
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;

endmodule

// File: sv/fp8_block_scaled_dot_accumulator.sv
// the lane products of an item go one per fp32 add through the shared two-stage adder,
// one after the other; a new item is taken only once the last lane sum is back
// an item that closes a block then goes through scale product, scaling and accumulate
// an item with tlast then loads the output register once it is free; the result shows
// on m_axis the cycle after; reset clears the sums, the block count and the output valid
module fp8_block_scaled_dot_accumulator #(
  parameter int SCALE_BLOCK = 128,
  parameter int LANES       = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // a_lane0..a_lane(LANES-1), b_lane0..b_lane(LANES-1), scale_a_bits, scale_b_bits
  input  logic [16*LANES+63:0]    s_axis_tdata,
  input  logic                    s_axis_tlast,  // is_last
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // result_bf16
  output logic [15:0]             m_axis_tdata
);

  localparam int IPB = (SCALE_BLOCK / LANES) > 0 ? (SCALE_BLOCK / LANES) : 1;
  localparam int IW  = $clog2(IPB + 1);
  localparam int LW  = (LANES > 1) ? $clog2(LANES) : 1;

  fbsda_pkg::st_e st_q, st_d;

  logic [31:0] prod [LANES];
  logic        take;

  logic [LW-1:0] idx_q, idx_d;
  logic [IW-1:0] items_q, items_d;
  logic [31:0]   part_q, part_d, total_q, total_d;
  logic [31:0]   sa_q, sb_q, s_q, s_d, scl_q, scl_d;
  logic          last_q;
  logic          add_pend_q, add_pend_d, mul_pend_q, mul_pend_d;
  logic          out_vld_q, out_vld_d;
  logic [15:0]   out_q, out_d;

  logic        add_go, mul_go, add_vld, mul_vld;
  logic [31:0] add_a, add_b, mul_a, mul_b, add_res, mul_res;

  assign take = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fbsda_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (take),
      .a_i    (s_axis_tdata[8*g +: 8]),
      .b_i    (s_axis_tdata[8*(LANES+g) +: 8]),
      .prod_o (prod[g])
    );
  end

  fbsda_fadd u_fadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (add_go),
    .a_i     (add_a),
    .b_i     (add_b),
    .valid_o (add_vld),
    .res_o   (add_res)
  );

  fbsda_fmul u_fmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .valid_o (mul_vld),
    .res_o   (mul_res)
  );

  always_comb begin
    st_d       = st_q;
    idx_d      = idx_q;
    items_d    = items_q;
    part_d     = part_q;
    total_d    = total_q;
    s_d        = s_q;
    scl_d      = scl_q;
    add_pend_d = add_pend_q;
    mul_pend_d = mul_pend_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_d      = out_q;
    add_go     = 1'b0;
    mul_go     = 1'b0;
    add_a      = part_q;
    add_b      = prod[idx_q];
    mul_a      = sa_q;
    mul_b      = sb_q;
    s_axis_tready = 1'b0;

    unique case (st_q)
      fbsda_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (take) begin
          idx_d = '0;
          st_d  = fbsda_pkg::ST_ACC;
        end
      end
      fbsda_pkg::ST_ACC: begin
        if (!add_pend_q) begin
          add_go     = 1'b1;
          add_pend_d = 1'b1;
        end else if (add_vld) begin
          add_pend_d = 1'b0;
          part_d     = add_res;
          if (idx_q == LW'(LANES - 1)) begin
            items_d = items_q + IW'(1);
            if (items_q + IW'(1) >= IW'(IPB)) st_d = fbsda_pkg::ST_SMUL;
            else if (last_q)                st_d = fbsda_pkg::ST_FIN;
            else                            st_d = fbsda_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + LW'(1);
          end
        end
      end
      fbsda_pkg::ST_SMUL: begin
        if (!mul_pend_q) begin
          mul_go     = 1'b1;
          mul_pend_d = 1'b1;
        end else if (mul_vld) begin
          mul_pend_d = 1'b0;
          s_d        = mul_res;
          st_d       = fbsda_pkg::ST_PMUL;
        end
      end
      fbsda_pkg::ST_PMUL: begin
        mul_a = part_q;
        mul_b = s_q;
        if (!mul_pend_q) begin
          mul_go     = 1'b1;
          mul_pend_d = 1'b1;
        end else if (mul_vld) begin
          mul_pend_d = 1'b0;
          scl_d      = mul_res;
          st_d       = fbsda_pkg::ST_TADD;
        end
      end
      fbsda_pkg::ST_TADD: begin
        add_a = total_q;
        add_b = scl_q;
        if (!add_pend_q) begin
          add_go     = 1'b1;
          add_pend_d = 1'b1;
        end else if (add_vld) begin
          add_pend_d = 1'b0;
          total_d    = add_res;
          part_d     = '0;
          items_d    = '0;
          st_d       = last_q ? fbsda_pkg::ST_FIN : fbsda_pkg::ST_IDLE;
        end
      end
      fbsda_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = fbsda_pkg::to_bf16(total_q);
          part_d    = '0;
          total_d   = '0;
          items_d   = '0;
          st_d      = fbsda_pkg::ST_IDLE;
        end
      end
      default: st_d = fbsda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= fbsda_pkg::ST_IDLE;
      idx_q      <= '0;
      items_q    <= '0;
      part_q     <= '0;
      total_q    <= '0;
      add_pend_q <= 1'b0;
      mul_pend_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      idx_q      <= idx_d;
      items_q    <= items_d;
      part_q     <= part_d;
      total_q    <= total_d;
      add_pend_q <= add_pend_d;
      mul_pend_q <= mul_pend_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sa_q   <= s_axis_tdata[16*LANES +: 32];
      sb_q   <= s_axis_tdata[16*LANES+32 +: 32];
      last_q <= s_axis_tlast;
    end
    s_q   <= s_d;
    scl_q <= scl_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!add_pend_q && !mul_pend_q))
    else $error("item taken while an fp unit is busy");

  // the count sits at the block size while the block is being scaled
  a_block_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= IW'(IPB))
    else $error("block item count out of range");

  a_add_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_go |-> ##2 add_vld)
    else $error("adder result missing");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(add_pend_q && mul_pend_q))
    else $error("adder and multiplier busy together");

endmodule

// File: sim/tb_fp8_block_scaled_dot_accumulator.sv
`timescale 1ns / 100ps

module tb_fp8_block_scaled_dot_accumulator;

  localparam int LANES       = 4;
  localparam int SCALE_BLOCK = 128;
  localparam int BLOCK_ITEMS = SCALE_BLOCK / LANES;
  localparam int DW          = 16 * LANES + 64;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

  typedef struct {
    logic [DW-1:0] data;
    logic          last;
  } dot_item_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [15:0]   m_axis_tdata;

  fp8_block_scaled_dot_accumulator #(
    .SCALE_BLOCK(SCALE_BLOCK),
    .LANES      (LANES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // a_lane0..3, b_lane0..3, scale_a_bits, scale_b_bits
    .s_axis_tlast (s_axis_tlast),   // is_last
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // result_bf16
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dot_item_t   pending_items[$];
  logic [15:0] expected_bf16[$];
  int          error_count = 0;
  int          items_taken = 0;
  int          items_queued = 0;

  // predictor state
  logic [31:0] block_sum;
  logic [31:0] total_sum;
  int          block_count;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------- fp32 arithmetic, round to nearest even ----------------

  // value = sig * 2^e
  function automatic logic [31:0] f32_round(logic s, logic [63:0] sig, int e);
    int p;
    int sh;
    int re;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    if (sig == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) p = i;
    sh = p - 23;
    if (e + sh < -149) sh = -149 - e;
    re = e + sh;
    if (sh > 60) return {s, 31'd0};
    if (sh > 0) begin
      keep = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    end else begin
      keep = sig << (-sh);
    end
    if (keep == (64'd1 << 24)) begin
      keep = keep >> 1;
      re++;
    end
    if (keep >= (64'd1 << 23)) begin
      if (re + 150 >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(re + 150), keep[22:0]};
    end
    return {s, 8'd0, keep[22:0]};
  endfunction

  function automatic void f32_split(input logic [31:0] x, output logic [63:0] sig,
                                    output int e);
    if (x[30:23] == 8'd0) begin
      sig = {41'd0, x[22:0]};
      e   = -149;
    end else begin
      sig = {40'd0, 1'b1, x[22:0]};
      e   = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic f32_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic logic f32_inf(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 0;
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic [63:0] sa;
    logic [63:0] sb;
    int ea;
    int eb;
    logic s;
    s = a[31] ^ b[31];
    if (f32_nan(a) || f32_nan(b)) return F32_QNAN;
    if (f32_inf(a) || f32_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return F32_QNAN;
      return {s, 8'hFF, 23'd0};
    end
    f32_split(a, sa, ea);
    f32_split(b, sb, eb);
    return f32_round(s, sa * sb, ea + eb);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] big;
    logic [63:0] sml;
    logic [63:0] sum;
    logic [31:0] t;
    int ea;
    int eb;
    int d;
    logic s;
    if (f32_nan(a) || f32_nan(b)) return F32_QNAN;
    if (f32_inf(a) && f32_inf(b) && a[31] != b[31]) return F32_QNAN;
    if (f32_inf(a)) return a;
    if (f32_inf(b)) return b;
    if (a[30:23] < b[30:23]) begin
      t = a;
      a = b;
      b = t;
    end
    f32_split(a, sa, ea);
    f32_split(b, sb, eb);
    big = sa << 31;
    d   = ea - eb;
    if (d <= 31) begin
      sml = sb << (31 - d);
    end else if (d - 31 >= 40) begin
      sml = (sb != 0) ? 64'd1 : 64'd0;
    end else begin
      // lost bits fold into a sticky lsb far below the guard position
      sml = (sb >> (d - 31)) | {63'd0, (sb & ((64'd1 << (d - 31)) - 1)) != 0};
    end
    if (a[31] == b[31]) begin
      sum = big + sml;
      s   = a[31];
    end else if (big >= sml) begin
      sum = big - sml;
      s   = a[31];
    end else begin
      sum = sml - big;
      s   = b[31];
    end
    if (sum == 0) return {a[31] & b[31], 31'd0};
    return f32_round(s, sum, ea - 31);
  endfunction

  function automatic logic [31:0] e4m3_to_f32(logic [7:0] v);
    if (v[6:0] == 7'h7F) return {v[7], 31'h7FC0_0000};
    if (v[6:3] == 4'd0) return f32_round(v[7], {61'd0, v[2:0]}, -9);
    return {v[7], 8'(int'(v[6:3]) + 120), v[2:0], 20'd0};
  endfunction

  function automatic logic [15:0] f32_to_bf16_rne(logic [31:0] b);
    logic [31:0] t;
    if (f32_nan(b)) return {b[31], 15'h7FC0};
    t = b + 32'h0000_7FFF + {31'd0, b[16]};
    return t[31:16];
  endfunction

  task automatic accumulate_item(input dot_item_t it);
    logic [31:0] pa;
    logic [31:0] pb;
    logic [31:0] sc;
    for (int i = 0; i < LANES; i++) begin
      pa = e4m3_to_f32(it.data[8*i +: 8]);
      pb = e4m3_to_f32(it.data[8*(LANES+i) +: 8]);
      block_sum = f32_add(block_sum, f32_mul(pa, pb));
    end
    block_count++;
    if (block_count >= BLOCK_ITEMS) begin
      sc        = f32_mul(it.data[16*LANES +: 32], it.data[16*LANES+32 +: 32]);
      total_sum = f32_add(total_sum, f32_mul(block_sum, sc));
      block_sum   = '0;
      block_count = 0;
    end
    if (it.last) begin
      expected_bf16.push_back(f32_to_bf16_rne(total_sum));
      block_sum   = '0;
      total_sum   = '0;
      block_count = 0;
    end
  endtask

  // ---------------- stimulus generation ----------------

  function automatic logic [7:0] pick_lane(bit extremes);
    logic [7:0] v;
    logic [7:0] ext [8] = '{8'h7E, 8'hFE, 8'h00, 8'h80, 8'h01, 8'h81, 8'h08, 8'h77};
    if (extremes) return ext[$urandom_range(0, 7)];
    v = 8'($urandom);
    // keep nan lanes rare so most sums stay finite
    if (v[6:0] == 7'h7F && $urandom_range(0, 99) != 0) v[0] = 1'b0;
    return v;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return {$urandom_range(0, 1) == 1, 31'd0};
      2: return {1'($urandom), 8'hFE, 23'($urandom)};
      3: return {1'($urandom), 8'h00, 23'($urandom)};
      4: return {1'($urandom), 8'hFF, 23'd0};
      default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endcase
  endfunction

  task automatic queue_item(input logic [31:0] lanes_a, input logic [31:0] lanes_b,
                            input logic last);
    dot_item_t it;
    it.data = {pick_scale(), pick_scale(), lanes_b, lanes_a};
    it.last = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_run(input int len, input bit extremes);
    logic [31:0] la;
    logic [31:0] lb;
    for (int k = 0; k < len; k++) begin
      for (int i = 0; i < LANES; i++) begin
        la[8*i +: 8] = pick_lane(extremes);
        lb[8*i +: 8] = pick_lane(extremes);
      end
      queue_item(la, lb, k == len - 1);
    end
  endtask

  // ---------------- driver ----------------
  dot_item_t cur_item;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk_i) begin
    logic vld;
    vld = s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      accumulate_item(cur_item);
      items_taken++;
      vld = 1'b0;
    end
    if (!vld) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        s_axis_tdata <= cur_item.data;
        s_axis_tlast <= cur_item.last;
        vld = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
    s_axis_tvalid <= vld;
  end

  // ---------------- monitor ----------------
  int stall_left = 0;
  int calm_left = 0;

  always @(posedge clk_i) begin
    logic [15:0] exp_v;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_bf16.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        exp_v = expected_bf16.pop_front();
        // nan sign is left open, only the quiet pattern is required
        if (exp_v[14:7] == 8'hFF && exp_v[6:0] != 0) begin
          if (m_axis_tdata[14:0] != 15'h7FC0)
            report_mismatch($sformatf("result_bf16 %h, expected nan", m_axis_tdata));
        end else if (m_axis_tdata != exp_v) begin
          report_mismatch($sformatf("result_bf16 %h, expected %h", m_axis_tdata, exp_v));
        end
      end
    end
    if (calm_left > 0) begin
      calm_left--;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      case ($urandom_range(0, 7))
        0: calm_left = $urandom_range(20, 300);
        1, 2: stall_left = $urandom_range(1, 60);
        default: ;
      endcase
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int kind;
    block_sum   = '0;
    total_sum   = '0;
    block_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // last on the very first item, trailing part dropped
    queue_item(32'h7E7E_7E7E, 32'hFEFE_FEFE, 1'b1);
    // short runs with every extreme lane and nan lanes
    queue_item(32'h8001_007E, 32'h0181_80FE, 1'b0);
    queue_item(32'hFF7F_FF7F, 32'h7F7F_FFFF, 1'b0);
    queue_item(32'h0807_7780, 32'h7701_0800, 1'b1);
    queue_run(5, 1'b1);
    queue_run(4, 1'b0);

    while (items_queued < 1800) begin
      kind = $urandom_range(0, 19);
      if (kind < 10)      queue_run(BLOCK_ITEMS, 1'b0);
      else if (kind < 12) queue_run(BLOCK_ITEMS, 1'b1);
      else if (kind < 14) queue_run(2 * BLOCK_ITEMS, 1'b0);
      else if (kind < 15) queue_run(3 * BLOCK_ITEMS, 1'b0);
      else if (kind < 17) queue_run(BLOCK_ITEMS + $urandom_range(1, BLOCK_ITEMS - 1), 1'b0);
      else                queue_run($urandom_range(1, BLOCK_ITEMS - 1), 1'b0);
    end

    wait (items_taken == items_queued && expected_bf16.size() == 0);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_bf16.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
sv/fbsda_pkg.sv
sv/fbsda_lane.sv
sv/fbsda_fadd.sv
sv/fbsda_fmul.sv
sv/fp8_block_scaled_dot_accumulator.sv
sim/tb_fp8_block_scaled_dot_accumulator.sv
